### design/jfss_pkg.sv
package jfss_pkg;

    localparam logic [2:0] ST_FOUND     = 3'd0;
    localparam logic [2:0] ST_BAD_START = 3'd1;
    localparam logic [2:0] ST_NO_FRAME  = 3'd2;
    localparam logic [2:0] ST_BAD_LEN   = 3'd3;
    localparam logic [2:0] ST_SHORT     = 3'd4;

    localparam logic [7:0] MK_FILL = 8'hFF;
    localparam logic [7:0] MK_SOI  = 8'hD8;
    localparam logic [7:0] MK_SOS  = 8'hDA;
    localparam logic [7:0] MK_EOI  = 8'hD9;
    localparam logic [7:0] MK_SOF_FIRST = 8'hC0;
    localparam logic [7:0] MK_SOF_LAST  = 8'hCF;
    localparam logic [7:0] MK_DHT  = 8'hC4;
    localparam logic [7:0] MK_JPG  = 8'hC8;
    localparam logic [7:0] MK_DAC  = 8'hCC;

    typedef struct packed {
        logic is_fill;
        logic is_stop;
        logic is_sof;
    } marker_class_t;

endpackage

### design/jpeg_frame_size_scanner.sv
// JPEG frame size scanner.
// Input channel (in_valid / in_ready) carries one file byte per request in
// data_byte, with first_byte marking the start of a file and last_byte its end.
// Output channel (out_valid / out_ready) carries one status request per file:
// status, and image_width / image_height from the frame header (zero unless
// status is found).
// Each byte updates the scan state in the cycle it is taken; a result is
// presented from the output register in the cycle after the byte that caused it.
// Throughput is one byte per cycle: the state update is a single register
// step and the output register accepts a new result whenever it is empty or
// being taken in the same cycle.
// When the receiver stalls with a result pending, in_ready drops until that
// result is taken.
// Reset clears the scan state and the output valid flag; bytes seen before any
// first_byte are taken as the start of a file.
// Bytes after a file's result are dropped until the next first_byte.
module jpeg_frame_size_scanner (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [7:0]  data_byte,
    input  logic        first_byte,
    input  logic        last_byte,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [2:0]  status,
    output logic [15:0] image_width,
    output logic [15:0] image_height
);
    import jfss_pkg::*;

    typedef enum logic [3:0] {
        PH_SOI0, PH_SOI1, PH_HUNT, PH_MARK, PH_LENHI, PH_LENLO,
        PH_SKIP, PH_PREC, PH_HHI, PH_HLO, PH_WHI, PH_WLO
    } phase_t;

    phase_t        phase_reg, phase_next;
    logic [15:0]   skip_left_reg, skip_left_next;
    logic [7:0]    high_byte_hold_reg, high_byte_hold_next;
    logic [15:0]   height_hold_reg, height_hold_next;
    logic          is_sof_segment_reg, is_sof_segment_next;
    logic          reported_reg, reported_next;
    logic          out_valid_reg;
    logic [2:0]    status_reg;
    logic [15:0]   width_reg, height_reg;

    logic          in_accept;
    logic          emit;
    logic [2:0]    emit_status;
    logic [15:0]   emit_width, emit_height;
    marker_class_t cls;

    jfss_marker_class u_class (
        .code (data_byte),
        .cls  (cls)
    );

    assign in_ready  = !out_valid_reg || out_ready;
    assign in_accept = in_valid && in_ready;

    always_comb
    begin
        phase_t      ph;
        logic        rep;
        logic [15:0] len;
        ph  = first_byte ? PH_SOI0 : phase_reg;
        rep = first_byte ? 1'b0 : reported_reg;
        len = {high_byte_hold_reg, data_byte};

        phase_next          = ph;
        skip_left_next      = skip_left_reg;
        high_byte_hold_next = high_byte_hold_reg;
        height_hold_next    = height_hold_reg;
        is_sof_segment_next = is_sof_segment_reg;
        emit        = 1'b0;
        emit_status = ST_SHORT;
        emit_width  = '0;
        emit_height = '0;

        if (!rep)
        begin
            unique case (ph)
                PH_SOI0:
                begin
                    if (data_byte != MK_FILL || last_byte)
                    begin
                        emit        = 1'b1;
                        emit_status = ST_BAD_START;
                    end
                    phase_next = PH_SOI1;
                end
                PH_SOI1:
                begin
                    if (data_byte != MK_SOI)
                    begin
                        emit        = 1'b1;
                        emit_status = ST_BAD_START;
                    end
                    phase_next = PH_HUNT;
                end
                PH_HUNT:
                begin
                    if (cls.is_fill)
                    begin
                        phase_next = PH_MARK;
                    end
                end
                PH_MARK:
                begin
                    if (cls.is_stop)
                    begin
                        emit        = 1'b1;
                        emit_status = ST_NO_FRAME;
                    end
                    else if (!cls.is_fill)
                    begin
                        is_sof_segment_next = cls.is_sof;
                        phase_next          = PH_LENHI;
                    end
                end
                PH_LENHI:
                begin
                    high_byte_hold_next = data_byte;
                    phase_next          = PH_LENLO;
                end
                PH_LENLO:
                begin
                    if (len < 16'd2)
                    begin
                        emit        = 1'b1;
                        emit_status = ST_BAD_LEN;
                    end
                    else if (is_sof_segment_reg)
                    begin
                        phase_next = PH_PREC;
                    end
                    else
                    begin
                        skip_left_next = len - 16'd2;
                        phase_next     = (len != 16'd2) ? PH_SKIP : PH_HUNT;
                    end
                end
                PH_SKIP:
                begin
                    skip_left_next = skip_left_reg - 16'd1;
                    if (skip_left_reg == 16'd1)
                    begin
                        phase_next = PH_HUNT;
                    end
                end
                PH_PREC:
                begin
                    phase_next = PH_HHI;
                end
                PH_HHI:
                begin
                    high_byte_hold_next = data_byte;
                    phase_next          = PH_HLO;
                end
                PH_HLO:
                begin
                    height_hold_next = len;
                    phase_next       = PH_WHI;
                end
                PH_WHI:
                begin
                    high_byte_hold_next = data_byte;
                    phase_next          = PH_WLO;
                end
                PH_WLO:
                begin
                    emit        = 1'b1;
                    emit_status = ST_FOUND;
                    emit_width  = len;
                    emit_height = height_hold_reg;
                end
                default:
                begin
                    phase_next = PH_HUNT;
                end
            endcase
            if (!emit && last_byte)
            begin
                emit        = 1'b1;
                emit_status = ST_SHORT;
            end
        end
        reported_next = rep || emit;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg          <= PH_SOI0;
            skip_left_reg      <= '0;
            high_byte_hold_reg <= '0;
            height_hold_reg    <= '0;
            is_sof_segment_reg <= 1'b0;
            reported_reg       <= 1'b0;
            out_valid_reg      <= 1'b0;
        end
        else
        begin
            if (in_accept)
            begin
                phase_reg          <= phase_next;
                skip_left_reg      <= skip_left_next;
                high_byte_hold_reg <= high_byte_hold_next;
                height_hold_reg    <= height_hold_next;
                is_sof_segment_reg <= is_sof_segment_next;
                reported_reg       <= reported_next;
            end
            if (in_accept && emit)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_accept && emit)
        begin
            status_reg <= emit_status;
            width_reg  <= emit_width;
            height_reg <= emit_height;
        end
    end

    assign out_valid    = out_valid_reg;
    assign status       = status_reg;
    assign image_width  = width_reg;
    assign image_height = height_reg;

    a_size_zero_on_fail: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && status != ST_FOUND |-> image_width == 16'd0 && image_height == 16'd0)
        else $error("size not zero on failure status");

    a_one_per_file: assert property (@(posedge clk) disable iff (!rst_n)
        in_accept && reported_reg && !first_byte |-> !emit)
        else $error("second result for one file");

    a_last_reports: assert property (@(posedge clk) disable iff (!rst_n)
        in_accept && last_byte && (first_byte || !reported_reg) |-> emit)
        else $error("file ended without a result");

    a_stall_only: assert property (@(posedge clk) disable iff (!rst_n)
        !in_ready |-> out_valid && !out_ready)
        else $error("input stalled without a pending result");

endmodule

### design/jfss_marker_class.sv
module jfss_marker_class (
    input  logic [7:0]             code,
    output jfss_pkg::marker_class_t cls
);
    import jfss_pkg::*;

    always_comb
    begin
        cls.is_fill = (code == MK_FILL);
        cls.is_stop = (code == MK_SOS) || (code == MK_EOI);
        cls.is_sof  = (code >= MK_SOF_FIRST) && (code <= MK_SOF_LAST)
                      && (code != MK_DHT) && (code != MK_JPG) && (code != MK_DAC);
    end

endmodule

### tb/sv/jpeg_frame_size_scanner_tb.sv
`timescale 1ns / 1ps

module jpeg_frame_size_scanner_tb;

    import jfss_pkg::*;

    typedef enum logic [3:0] {
        SCAN_SOI_HI,
        SCAN_SOI_LO,
        SCAN_HUNT,
        SCAN_MARKER,
        SCAN_LEN_HI,
        SCAN_LEN_LO,
        SCAN_SKIP,
        SCAN_PREC,
        SCAN_H_HI,
        SCAN_H_LO,
        SCAN_W_HI,
        SCAN_W_LO
    } scan_phase_t;

    typedef struct packed {
        logic [2:0]  status;
        logic [15:0] width;
        logic [15:0] height;
    } size_result_t;

    class frame_size_board;
        scan_phase_t  phase;
        logic [15:0]  skip_count;
        logic [7:0]   hi_byte;
        logic [15:0]  height_q;
        bit           frame_seg;
        bit           done;
        size_result_t size_results_q[$];
        int unsigned  errors;

        function new();
            restart();
            errors = 0;
        endfunction

        function void restart();
            phase = SCAN_SOI_HI;
            skip_count = '0;
            hi_byte = '0;
            height_q = '0;
            frame_seg = 1'b0;
            done = 1'b0;
        endfunction

        function bit scan_byte(input logic [7:0] b, input bit is_last,
                               output size_result_t r);
            logic [15:0] pair;
            r = '0;
            pair = {hi_byte, b};
            case (phase)
                SCAN_SOI_HI:
                begin
                    if (b != MK_FILL || is_last)
                    begin
                        r.status = ST_BAD_START;
                        return 1'b1;
                    end
                    phase = SCAN_SOI_LO;
                end
                SCAN_SOI_LO:
                begin
                    if (b != MK_SOI)
                    begin
                        r.status = ST_BAD_START;
                        return 1'b1;
                    end
                    phase = SCAN_HUNT;
                end
                SCAN_MARKER:
                begin
                    if (b != MK_FILL)
                    begin
                        if (b == MK_SOS || b == MK_EOI)
                        begin
                            r.status = ST_NO_FRAME;
                            return 1'b1;
                        end
                        frame_seg = b >= MK_SOF_FIRST && b <= MK_SOF_LAST &&
                                    b != MK_DHT && b != MK_JPG && b != MK_DAC;
                        phase = SCAN_LEN_HI;
                    end
                end
                SCAN_LEN_HI:
                begin
                    hi_byte = b;
                    phase = SCAN_LEN_LO;
                end
                SCAN_LEN_LO:
                begin
                    if (pair < 16'd2)
                    begin
                        r.status = ST_BAD_LEN;
                        return 1'b1;
                    end
                    if (frame_seg)
                    begin
                        phase = SCAN_PREC;
                    end
                    else
                    begin
                        skip_count = pair - 16'd2;
                        phase = (skip_count != 0) ? SCAN_SKIP : SCAN_HUNT;
                    end
                end
                SCAN_SKIP:
                begin
                    skip_count = skip_count - 16'd1;
                    if (skip_count == 0)
                        phase = SCAN_HUNT;
                end
                SCAN_PREC:
                begin
                    phase = SCAN_H_HI;
                end
                SCAN_H_HI:
                begin
                    hi_byte = b;
                    phase = SCAN_H_LO;
                end
                SCAN_H_LO:
                begin
                    height_q = pair;
                    phase = SCAN_W_HI;
                end
                SCAN_W_HI:
                begin
                    hi_byte = b;
                    phase = SCAN_W_LO;
                end
                SCAN_W_LO:
                begin
                    r.status = ST_FOUND;
                    r.width = pair;
                    r.height = height_q;
                    return 1'b1;
                end
                default:
                begin
                    if (b == MK_FILL)
                        phase = SCAN_MARKER;
                end
            endcase
            if (is_last)
            begin
                r.status = ST_SHORT;
                return 1'b1;
            end
            return 1'b0;
        endfunction

        function void note_byte(input logic [7:0] b, input bit f, input bit l);
            size_result_t r;
            if (f)
                restart();
            if (done)
                return;
            if (scan_byte(b, l, r))
            begin
                done = 1'b1;
                size_results_q.insert(size_results_q.size(), r);
            end
        endfunction

        function void check_result(input logic [2:0] st, input logic [15:0] w,
                                   input logic [15:0] h);
            size_result_t want;
            if (size_results_q.size() == 0)
            begin
                $error("status request with no result pending: status %0d", st);
                errors++;
                return;
            end
            want = size_results_q.pop_front();
            if (st !== want.status)
            begin
                $error("status: expected %0d, got %0d", want.status, st);
                errors++;
            end
            if (w !== want.width)
            begin
                $error("image_width: expected %0d, got %0d", want.width, w);
                errors++;
            end
            if (h !== want.height)
            begin
                $error("image_height: expected %0d, got %0d", want.height, h);
                errors++;
            end
        endfunction

        function int pending();
            return size_results_q.size();
        endfunction
    endclass

    localparam int IDLE_LIMIT = 2000;

    logic        clk = 1'b0;
    logic        rst_n;
    logic        in_valid;
    logic        in_ready;
    logic [7:0]  data_byte;
    logic        first_byte;
    logic        last_byte;
    logic        out_valid;
    logic        out_ready;
    logic [2:0]  status;
    logic [15:0] image_width;
    logic [15:0] image_height;

    frame_size_board board;
    logic [7:0]      file_buf[$];
    int              in_gap_pct;
    int              out_stall_pct;
    int unsigned     bytes_sent;
    int unsigned     quiet_cycles;

    jpeg_frame_size_scanner u_top (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .data_byte    (data_byte),
        .first_byte   (first_byte),
        .last_byte    (last_byte),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .status       (status),
        .image_width  (image_width),
        .image_height (image_height)
    );

    always #5 clk = ~clk;

    function automatic bit roll(input int pct);
        return $urandom_range(0, 99) < pct;
    endfunction

    function automatic logic [7:0] rand_byte(input int unsigned lo, input int unsigned hi);
        return 8'($urandom_range(lo, hi));
    endfunction

    function automatic void append_byte(input logic [7:0] b);
        file_buf.insert(file_buf.size(), b);
    endfunction

    always @(posedge clk)
        out_ready <= !roll(out_stall_pct);

    always @(posedge clk)
    begin
        if (in_valid && in_ready)
            board.note_byte(data_byte, first_byte, last_byte);
        if (out_valid && out_ready)
            board.check_result(status, image_width, image_height);
        if ((in_valid && in_ready) || (out_valid && out_ready))
        begin
            quiet_cycles = 0;
        end
        else
        begin
            quiet_cycles++;
            if (quiet_cycles == IDLE_LIMIT)
            begin
                $display("jpeg_frame_size_scanner regression: fail");
                $finish;
            end
        end
    end

    task automatic send_byte(input logic [7:0] b, input bit f, input bit l);
        while (roll(in_gap_pct))
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid   <= 1'b1;
        data_byte  <= b;
        first_byte <= f;
        last_byte  <= l;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        bytes_sent++;
    endtask

    task automatic send_file(input bit with_first, input bit with_last);
        int i;
        for (i = 0; i < file_buf.size(); i++)
            send_byte(file_buf[i], with_first && i == 0,
                      with_last && i == file_buf.size() - 1);
    endtask

    task automatic wait_drained();
        in_valid <= 1'b0;
        @(posedge clk);
        while (board.pending() != 0)
            @(posedge clk);
    endtask

    // optional stray byte in the hunt, then FF, optional fill, then the code
    task automatic add_marker(input logic [7:0] code);
        int n_fill;
        n_fill = ($urandom_range(0, 2) == 0) ? $urandom_range(1, 2) : 0;
        if ($urandom_range(0, 3) == 0)
            append_byte(rand_byte(0, 'hFE));
        append_byte(MK_FILL);
        repeat (n_fill)
            append_byte(MK_FILL);
        append_byte(code);
    endtask

    task automatic add_segment();
        int          seg_len;
        logic [7:0]  code;
        case ($urandom_range(0, 5))
            0: code = MK_DHT;
            1: code = MK_JPG;
            2: code = MK_DAC;
            3: code = rand_byte('hE0, 'hEF);
            4: code = rand_byte('hDB, 'hFE);
            default: code = rand_byte(0, 'hBF);
        endcase
        seg_len = ($urandom_range(0, 24) == 0) ? $urandom_range(9, 400) : $urandom_range(2, 8);
        add_marker(code);
        append_byte(seg_len[15:8]);
        append_byte(seg_len[7:0]);
        repeat (seg_len - 2)
            append_byte(rand_byte(0, 255));
    endtask

    task automatic build_good_file();
        int          frame_len;
        logic [7:0]  code;
        logic [15:0] dim;
        file_buf = '{MK_FILL, MK_SOI};
        repeat ($urandom_range(0, 2))
            add_segment();
        do
            code = rand_byte(int'(MK_SOF_FIRST), int'(MK_SOF_LAST));
        while (code == MK_DHT || code == MK_JPG || code == MK_DAC);
        add_marker(code);
        frame_len = ($urandom_range(0, 3) == 0) ? $urandom_range(2, 7) : $urandom_range(8, 20);
        append_byte(frame_len[15:8]);
        append_byte(frame_len[7:0]);
        append_byte(rand_byte(0, 255));
        repeat (2)
        begin
            if ($urandom_range(0, 3) == 0)
                dim = $urandom_range(0, 1) ? 16'hFFFF : 16'h0000;
            else
                dim = 16'($urandom_range(0, 'hFFFF));
            append_byte(dim[15:8]);
            append_byte(dim[7:0]);
        end
        repeat ($urandom_range(0, 3))
            append_byte(rand_byte(0, 255));
    endtask

    task automatic build_broken_file(output bit with_last);
        int keep;
        with_last = 1'b1;
        case ($urandom_range(0, 5))
            0, 5:
            begin
                build_good_file();
                keep = $urandom_range(1, file_buf.size() - 1);
                while (file_buf.size() > keep)
                    void'(file_buf.pop_back());
                if ($urandom_range(0, 2) == 0)
                    with_last = 1'b0;
            end
            1:
            begin
                build_good_file();
                file_buf[$urandom_range(0, file_buf.size() - 1)] = rand_byte(0, 255);
            end
            2:
            begin
                file_buf = '{MK_FILL, MK_SOI};
                repeat ($urandom_range(0, 1))
                    add_segment();
                add_marker($urandom_range(0, 1) ? MK_SOS : MK_EOI);
                repeat ($urandom_range(0, 2))
                    append_byte(rand_byte(0, 255));
            end
            3:
            begin
                file_buf = '{MK_FILL, MK_SOI};
                repeat ($urandom_range(0, 1))
                    add_segment();
                add_marker(rand_byte(0, 'hFE));
                append_byte(8'h00);
                append_byte(rand_byte(0, 1));
                repeat ($urandom_range(0, 2))
                    append_byte(rand_byte(0, 255));
            end
            default:
            begin
                file_buf.delete();
                repeat ($urandom_range(1, 12))
                    append_byte(rand_byte(0, 255));
            end
        endcase
    endtask

    initial
    begin
        int unsigned file_no;
        bit          with_last;
        rst_n         = 1'b0;
        in_valid      = 1'b0;
        data_byte     = '0;
        first_byte    = 1'b0;
        last_byte     = 1'b0;
        out_ready     = 1'b0;
        in_gap_pct    = 26;
        out_stall_pct = 26;
        bytes_sent    = 0;
        quiet_cycles  = 0;
        board         = new();
        repeat (12)
            @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // no first_byte after reset; short frame header; largest size
        file_buf = '{MK_FILL, MK_SOI, MK_FILL, MK_SOF_FIRST, 8'h00, 8'h02, 8'h08,
                     8'hFF, 8'hFF, 8'hFF, 8'hFF};
        send_file(1'b0, 1'b1);
        file_buf = '{MK_FILL};
        send_file(1'b1, 1'b1);
        file_buf = '{8'h00};
        send_file(1'b1, 1'b1);
        file_buf = '{MK_FILL, MK_SOI};
        send_file(1'b1, 1'b1);
        // bad second byte, trailing byte dropped
        file_buf = '{MK_FILL, 8'h00, 8'hAA};
        send_file(1'b1, 1'b1);
        file_buf = '{MK_FILL, MK_SOI, MK_FILL, MK_FILL, MK_EOI};
        send_file(1'b1, 1'b1);
        // marker code 00 followed by a length of 1
        file_buf = '{MK_FILL, MK_SOI, MK_FILL, 8'h00, 8'h00, 8'h01};
        send_file(1'b1, 1'b1);
        wait_drained();

        file_no = 0;
        while (bytes_sent < 450)
        begin
            in_gap_pct    = (file_no >= 1 && file_no < 5) ? 0 : 26;
            out_stall_pct = in_gap_pct;
            if (file_no == 6)
                wait_drained();
            if ($urandom_range(0, 9) < 7)
            begin
                build_good_file();
                send_file(1'b1, 1'b1);
            end
            else
            begin
                build_broken_file(with_last);
                send_file(1'b1, with_last);
            end
            file_no++;
        end

        wait_drained();
        repeat (8)
            @(posedge clk);
        if (board.errors == 0 && board.pending() == 0)
            $display("jpeg_frame_size_scanner regression: pass");
        else
            $display("jpeg_frame_size_scanner regression: fail");
        $finish;
    end

endmodule
